[hdl/sdspi_pkg.sv]
// Shared types, constants and response codes for the SD card SPI command engine.
package sdspi_pkg;

    localparam int RESP_DEPTH_DEF  = 4096;
    localparam int MAX_BLOCK_DEF   = 2048;
    localparam int STORE_BYTES_DEF = 65536;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SET_BLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_BLK  = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
    localparam logic [5:0] CMD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;

    localparam logic [7:0] R_IDLE     = 8'h01;
    localparam logic [7:0] R_OK       = 8'h00;
    localparam logic [7:0] R_ILLEGAL  = 8'h05;
    localparam logic [7:0] R_ADDR_ERR = 8'h20;
    localparam logic [7:0] R_TOKEN    = 8'hFE;
    localparam logic [7:0] R_FILL     = 8'hFF;
    localparam logic [7:0] R_DATA_OK  = 8'hE5;
    localparam logic [7:0] R_DATA_BAD = 8'hED;
    localparam logic [7:0] R_CRC      = 8'h01;

    localparam logic [2:0] FRAME_LEN = 3'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] mosi_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       overflow;
    } out_beat_t;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_STORE_RD,
        OP_STORE_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [7:0] push_byte;
        logic       push_from_store;
        logic       clear_queue;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0] pop_byte;
        logic       overflowed;
    } dp_stat_t;

endpackage

[hdl/sdspi_ram.sv]
// Generic single-port RAM with registered read data.
module sdspi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; read data appears the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/sdspi_datapath.sv]
// Response queue and card byte store with their pointers and overflow flag.
module sdspi_datapath #(
    parameter int RESP_DEPTH  = sdspi_pkg::RESP_DEPTH_DEF,
    parameter int STORE_BYTES = sdspi_pkg::STORE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sdspi_pkg::dp_cmd_t             cmd,
    input  logic [$clog2(STORE_BYTES)-1:0] store_addr,
    input  logic [7:0]                     store_wdata,
    output sdspi_pkg::dp_stat_t            stat,
    output logic                           q_empty
);

    localparam int QW = $clog2(RESP_DEPTH);
    localparam int SW = $clog2(STORE_BYTES);

    logic [QW-1:0] rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic          ovf_reg, ovf_next;
    logic [QW-1:0] wr_inc, rd_inc, q_addr;
    logic          q_we, s_we;
    logic [7:0]    q_wdata, q_rdata, s_rdata;

    assign wr_inc  = (wr_ptr_reg == QW'(RESP_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc  = (rd_ptr_reg == QW'(RESP_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign q_empty = (rd_ptr_reg == wr_ptr_reg);

    // Pointer and overflow update for clear, push and pop.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        ovf_next    = ovf_reg;
        q_we        = 1'b0;
        q_addr      = rd_ptr_reg;
        q_wdata     = cmd.push_from_store ? s_rdata : cmd.push_byte;
        if (cmd.clear_queue)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            ovf_next    = 1'b0;
        end
        else if (cmd.op == sdspi_pkg::OP_PUSH)
        begin
            q_addr = wr_ptr_reg;
            if (wr_inc == rd_ptr_reg)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                q_we        = 1'b1;
                wr_ptr_next = wr_inc;
            end
        end
        else if (cmd.op == sdspi_pkg::OP_POP)
        begin
            if (!q_empty)
            begin
                rd_ptr_next = rd_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign s_we = (cmd.op == sdspi_pkg::OP_STORE_WR);

    sdspi_ram #(.WIDTH(8), .DEPTH(RESP_DEPTH)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    sdspi_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk   (clk),
        .we    (s_we),
        .addr  (store_addr[SW-1:0]),
        .wdata (store_wdata),
        .rdata (s_rdata)
    );

    assign stat.pop_byte   = q_rdata;
    assign stat.overflowed = ovf_reg;

endmodule

[hdl/sdspi_ctrl.sv]
// Command engine controller: frame gathering, command decode and block sequencing.
module sdspi_ctrl #(
    parameter int MAX_BLOCK   = sdspi_pkg::MAX_BLOCK_DEF,
    parameter int STORE_BYTES = sdspi_pkg::STORE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sdspi_pkg::in_beat_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sdspi_pkg::out_beat_t           out_data,
    output sdspi_pkg::dp_cmd_t             cmd,
    output logic [$clog2(STORE_BYTES)-1:0] store_addr,
    output logic [7:0]                     store_wdata,
    input  sdspi_pkg::dp_stat_t            stat,
    input  logic                           q_empty
);

    localparam int SW = $clog2(STORE_BYTES);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int IW = BW + 2;
    localparam logic [BW-1:0] BLEN_RST = BW'((MAX_BLOCK < 1024) ? MAX_BLOCK : 1024);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_POP   = 9'b0_0000_0010,
        S_TAKE  = 9'b0_0000_0100,
        S_PUSH  = 9'b0_0000_1000,
        S_RDREQ = 9'b0_0001_0000,
        S_RDPSH = 9'b0_0010_0000,
        S_OUT   = 9'b0_0100_0000,
        S_POPW  = 9'b0_1000_0000,
        S_CLR   = 9'b1_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic           sel_reg, sel_next, app_reg, app_next;
    logic           wph_reg, wph_next, tok_reg, tok_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [7:0]     hdr_reg [6];
    logic [7:0]     hdr_next [6];
    logic [BW-1:0]  blen_reg, blen_next;
    logic [29:0]    waddr_reg, waddr_next;
    logic [31:0]    arg;
    logic [7:0]     miso_reg, miso_next, mosi_reg, mosi_next;
    // Pending response bytes: up to three fixed bytes, then optional block read.
    logic [7:0]     pb_reg [3];
    logic [7:0]     pb_next [3];
    logic [1:0]     pn_reg, pn_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [BW-1:0]  rcnt_reg, rcnt_next;
    logic [29:0]    raddr_reg, raddr_next;
    logic [SW-1:0]  clr_reg, clr_next;
    logic           q_empty_d;

    assign arg = {hdr_reg[1], hdr_reg[2], hdr_reg[3], hdr_reg[4]};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data.miso_byte = miso_reg;
    assign out_data.overflow  = stat.overflowed;

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        app_next     = app_reg;
        wph_next     = wph_reg;
        tok_next     = tok_reg;
        idx_next     = idx_reg;
        hdr_next     = hdr_reg;
        blen_next    = blen_reg;
        waddr_next   = waddr_reg;
        miso_next    = miso_reg;
        mosi_next    = mosi_reg;
        pb_next      = pb_reg;
        pn_next      = pn_reg;
        rd_pend_next = rd_pend_reg;
        rcnt_next    = rcnt_reg;
        raddr_next   = raddr_reg;
        clr_next     = clr_reg;
        cmd          = '{op: sdspi_pkg::OP_NONE, push_byte: pb_reg[0],
                         push_from_store: 1'b0, clear_queue: 1'b0};
        store_addr   = SW'(raddr_reg);
        store_wdata  = mosi_reg;
        unique case (state_reg)
            S_CLR:
            begin
                // Zero the card store one byte per cycle after reset.
                cmd.op      = sdspi_pkg::OP_STORE_WR;
                store_addr  = clr_reg;
                store_wdata = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == SW'(STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mosi_next = in_data.mosi_byte;
                    miso_next = sdspi_pkg::R_FILL;
                    if (in_data.command)
                    begin
                        cmd.clear_queue = 1'b1;
                        sel_next  = 1'b1;
                        app_next  = 1'b0;
                        wph_next  = 1'b0;
                        tok_next  = 1'b0;
                        idx_next  = '0;
                        for (int k = 0; k < 6; k++) hdr_next[k] = '0;
                        blen_next = BLEN_RST;
                        waddr_next = '0;
                        state_next = S_OUT;
                    end
                    else if (sel_reg)
                    begin
                        cmd.op = sdspi_pkg::OP_POP;
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_POP:
            begin
                // Queue read data registered at acceptance is valid in this cycle.
                if (!q_empty_d)
                begin
                    miso_next = stat.pop_byte;
                end
                state_next = S_POPW;
            end
            S_POPW:
            begin
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                pn_next = '0;
                rd_pend_next = 1'b0;
                state_next = S_PUSH;
                if (mosi_reg == 8'hFF && idx_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (!wph_reg)
                begin
                    hdr_next[idx_reg[2:0]] = mosi_reg;
                    if (idx_reg[2:0] == sdspi_pkg::FRAME_LEN - 3'd1)
                    begin
                        idx_next = '0;
                        app_next = 1'b0;
                        unique case (hdr_reg[0][5:0]) inside
                            sdspi_pkg::CMD_GO_IDLE:
                            begin
                                pb_next[0] = sdspi_pkg::R_IDLE; pn_next = 2'd1;
                            end
                            sdspi_pkg::CMD_APP:
                            begin
                                pb_next[0] = sdspi_pkg::R_IDLE; pn_next = 2'd1;
                                app_next = 1'b1;
                            end
                            sdspi_pkg::CMD_OP_COND:
                            begin
                                pb_next[0] = app_reg ? sdspi_pkg::R_OK : sdspi_pkg::R_ILLEGAL;
                                pn_next = 2'd1;
                            end
                            sdspi_pkg::CMD_SET_BLEN:
                            begin
                                blen_next = (arg > 32'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(arg);
                                pb_next[0] = sdspi_pkg::R_OK; pn_next = 2'd1;
                            end
                            sdspi_pkg::CMD_READ_BLK, sdspi_pkg::CMD_WRITE_BLK:
                            begin
                                if (arg[31:30] != 2'b00)
                                begin
                                    pb_next[0] = sdspi_pkg::R_ADDR_ERR; pn_next = 2'd1;
                                end
                                else if (hdr_reg[0][5:0] == sdspi_pkg::CMD_READ_BLK)
                                begin
                                    pb_next[0] = sdspi_pkg::R_OK;
                                    pb_next[1] = sdspi_pkg::R_FILL;
                                    pb_next[2] = sdspi_pkg::R_TOKEN;
                                    pn_next = 2'd3;
                                    rd_pend_next = 1'b1;
                                    rcnt_next = blen_reg;
                                    raddr_next = arg[29:0];
                                end
                                else
                                begin
                                    pb_next[0] = sdspi_pkg::R_OK;
                                    pb_next[1] = sdspi_pkg::R_FILL;
                                    pn_next = 2'd2;
                                    wph_next = 1'b1;
                                    tok_next = 1'b0;
                                    waddr_next = arg[29:0];
                                end
                            end
                            default:
                            begin
                                pb_next[0] = sdspi_pkg::R_ILLEGAL; pn_next = 2'd1;
                            end
                        endcase
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (idx_reg == '0)
                    begin
                        tok_next = (mosi_reg == sdspi_pkg::R_TOKEN);
                    end
                    else if (idx_reg <= IW'(blen_reg) && tok_reg)
                    begin
                        cmd.op = sdspi_pkg::OP_STORE_WR;
                        store_addr = SW'(waddr_reg) + SW'(idx_reg - 1'b1);
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 >= IW'(blen_reg) + IW'(3))
                    begin
                        idx_next = '0;
                        wph_next = 1'b0;
                        tok_next = 1'b0;
                        if (tok_reg)
                        begin
                            pb_next[0] = sdspi_pkg::R_DATA_OK;
                            pb_next[1] = sdspi_pkg::R_OK;
                            pb_next[2] = sdspi_pkg::R_FILL;
                            pn_next = 2'd3;
                        end
                        else
                        begin
                            pb_next[0] = sdspi_pkg::R_DATA_BAD;
                            pn_next = 2'd1;
                        end
                    end
                end
            end
            S_PUSH:
            begin
                // Drain fixed bytes, then the block read, then the two CRC bytes.
                if (pn_reg != '0)
                begin
                    cmd.op = sdspi_pkg::OP_PUSH;
                    pb_next[0] = pb_reg[1];
                    pb_next[1] = pb_reg[2];
                    pn_next = pn_reg - 1'b1;
                end
                else if (rd_pend_reg && rcnt_reg != '0)
                begin
                    cmd.op = sdspi_pkg::OP_STORE_RD;
                    state_next = S_RDREQ;
                end
                else if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                    pb_next[0] = sdspi_pkg::R_CRC;
                    pb_next[1] = sdspi_pkg::R_CRC;
                    pn_next = 2'd2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RDREQ:
            begin
                state_next = S_RDPSH;
            end
            S_RDPSH:
            begin
                cmd.op = sdspi_pkg::OP_PUSH;
                cmd.push_from_store = 1'b1;
                raddr_next = raddr_reg + 30'd1;
                rcnt_next  = rcnt_reg - 1'b1;
                state_next = S_PUSH;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Queue emptiness is sampled when the pop is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_empty_d <= 1'b1;
        end
        else if (state_reg == S_IDLE)
        begin
            q_empty_d <= q_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            sel_reg     <= 1'b0;
            app_reg     <= 1'b0;
            wph_reg     <= 1'b0;
            tok_reg     <= 1'b0;
            idx_reg     <= '0;
            blen_reg    <= BLEN_RST;
            waddr_reg   <= '0;
            pn_reg      <= '0;
            rd_pend_reg <= 1'b0;
            clr_reg     <= '0;
            for (int k = 0; k < 6; k++) hdr_reg[k] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            app_reg     <= app_next;
            wph_reg     <= wph_next;
            tok_reg     <= tok_next;
            idx_reg     <= idx_next;
            blen_reg    <= blen_next;
            waddr_reg   <= waddr_next;
            pn_reg      <= pn_next;
            rd_pend_reg <= rd_pend_next;
            clr_reg     <= clr_next;
            hdr_reg     <= hdr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        miso_reg  <= miso_next;
        mosi_reg  <= mosi_next;
        pb_reg    <= pb_next;
        rcnt_reg  <= rcnt_next;
        raddr_reg <= raddr_next;
    end

    // The controller never accepts and presents a result in the same cycle.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output handshakes overlap");
    // Outside a write phase the frame index stays below the frame length.
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !wph_reg |-> idx_reg < IW'(sdspi_pkg::FRAME_LEN))
        else $error("frame index out of range");
    // A result is only offered after an accepted beat.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) != S_IDLE || $past(in_valid))
        else $error("result without beat");

endmodule

[hdl/sd_card_spi_command_engine.sv]
// Top level of the SD card SPI-mode command engine.
// Each input beat either selects the card, which resets the engine, or exchanges one SPI
// byte, and every input beat yields exactly one output beat. Only one beat is in flight:
// in_ready is low from acceptance until the output beat is taken. After reset the engine
// first zeroes the card byte store, one byte per cycle, with in_ready low until it is done.
// A select, or an exchange while deselected, goes straight to its output beat. An exchange
// while selected first pops the response queue, then takes the byte and pushes any response
// bytes that the frame produces; a READ_BLOCK frame pushes each block byte read from the
// single port of the card store, and then the two CRC bytes.
module sd_card_spi_command_engine #(
    parameter int RESP_DEPTH  = sdspi_pkg::RESP_DEPTH_DEF,
    parameter int MAX_BLOCK   = sdspi_pkg::MAX_BLOCK_DEF,
    parameter int STORE_BYTES = sdspi_pkg::STORE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdspi_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdspi_pkg::out_beat_t out_data
);

    sdspi_pkg::dp_cmd_t             cmd;
    sdspi_pkg::dp_stat_t            stat;
    logic                           q_empty;
    logic [$clog2(STORE_BYTES)-1:0] store_addr;
    logic [7:0]                     store_wdata;

    sdspi_ctrl #(.MAX_BLOCK(MAX_BLOCK), .STORE_BYTES(STORE_BYTES)) u_ctrl (
        .clk (clk), .rst_n (rst_n),
        .in_valid (in_valid), .in_ready (in_ready), .in_data (in_data),
        .out_valid (out_valid), .out_ready (out_ready), .out_data (out_data),
        .cmd (cmd), .store_addr (store_addr), .store_wdata (store_wdata),
        .stat (stat), .q_empty (q_empty)
    );

    sdspi_datapath #(.RESP_DEPTH(RESP_DEPTH), .STORE_BYTES(STORE_BYTES)) u_dp (
        .clk (clk), .rst_n (rst_n), .cmd (cmd),
        .store_addr (store_addr), .store_wdata (store_wdata),
        .stat (stat), .q_empty (q_empty)
    );

endmodule

[tb/sd_card_spi_checker.sv]
// Checker for the SD card SPI command engine: predicts each output beat and compares it.
`timescale 1ns / 1ps

module sd_card_spi_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  sdspi_pkg::in_beat_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  sdspi_pkg::out_beat_t out_data,
    output int                   errors,
    output int                   pending
);

    localparam logic [7:0]  HOST_IDLE  = 8'hFF;
    localparam logic [31:0] ADDR_LIMIT = 32'h4000_0000;

    // Card state as the host should see it.
    logic        card_sel;
    logic        app_seen;
    logic        wr_phase;
    logic        tok_ok;
    int unsigned idx;
    logic [7:0]  hdr [6];
    int unsigned blk_len;
    logic [31:0] wr_addr;
    logic        resp_ovf;
    logic [7:0]  resp_fifo [$];
    logic [7:0]  card_mem [sdspi_pkg::STORE_BYTES_DEF];

    // Expected output beats, oldest first.
    sdspi_pkg::out_beat_t expected_beats [$];

    assign pending = expected_beats.size();

    function automatic int unsigned mem_index(logic [31:0] base, int unsigned off);
        return (base + off) % sdspi_pkg::STORE_BYTES_DEF;
    endfunction

    task automatic clear_engine();
        card_sel = 1'b0;
        app_seen = 1'b0;
        wr_phase = 1'b0;
        tok_ok   = 1'b0;
        idx      = 0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        blk_len  = (1024 < sdspi_pkg::MAX_BLOCK_DEF) ? 1024 : sdspi_pkg::MAX_BLOCK_DEF;
        wr_addr  = '0;
        resp_ovf = 1'b0;
        resp_fifo.delete();
    endtask

    // One slot of the ring is always kept free, so the fill limit is depth minus one.
    task automatic queue_resp(logic [7:0] b);
        if (resp_fifo.size() >= sdspi_pkg::RESP_DEPTH_DEF - 1)
            resp_ovf = 1'b1;
        else
            resp_fifo.push_back(b);
    endtask

    task automatic decode_frame();
        logic [31:0] arg;
        logic        next_app;
        arg      = {hdr[1], hdr[2], hdr[3], hdr[4]};
        next_app = 1'b0;
        case (hdr[0][5:0])
            sdspi_pkg::CMD_GO_IDLE: queue_resp(sdspi_pkg::R_IDLE);
            sdspi_pkg::CMD_APP:
            begin
                queue_resp(sdspi_pkg::R_IDLE);
                next_app = 1'b1;
            end
            sdspi_pkg::CMD_OP_COND:
                queue_resp(app_seen ? sdspi_pkg::R_OK : sdspi_pkg::R_ILLEGAL);
            sdspi_pkg::CMD_SET_BLEN:
            begin
                blk_len = (arg > sdspi_pkg::MAX_BLOCK_DEF) ? sdspi_pkg::MAX_BLOCK_DEF : arg;
                queue_resp(sdspi_pkg::R_OK);
            end
            sdspi_pkg::CMD_READ_BLK:
            begin
                if (arg >= ADDR_LIMIT)
                    queue_resp(sdspi_pkg::R_ADDR_ERR);
                else
                begin
                    queue_resp(sdspi_pkg::R_OK);
                    queue_resp(sdspi_pkg::R_FILL);
                    queue_resp(sdspi_pkg::R_TOKEN);
                    for (int unsigned i = 0; i < blk_len; i++)
                        queue_resp(card_mem[mem_index(arg, i)]);
                    queue_resp(sdspi_pkg::R_CRC);
                    queue_resp(sdspi_pkg::R_CRC);
                end
            end
            sdspi_pkg::CMD_WRITE_BLK:
            begin
                if (arg >= ADDR_LIMIT)
                    queue_resp(sdspi_pkg::R_ADDR_ERR);
                else
                begin
                    queue_resp(sdspi_pkg::R_OK);
                    queue_resp(sdspi_pkg::R_FILL);
                    wr_phase = 1'b1;
                    tok_ok   = 1'b0;
                    wr_addr  = arg;
                end
            end
            default: queue_resp(sdspi_pkg::R_ILLEGAL);
        endcase
        app_seen = next_app;
    endtask

    task automatic consume_byte(logic [7:0] b);
        if (!wr_phase)
        begin
            hdr[idx] = b;
            idx++;
            if (idx >= 6)
            begin
                idx = 0;
                decode_frame();
            end
        end
        else
        begin
            if (idx == 0)
                tok_ok = (b == sdspi_pkg::R_TOKEN);
            else if (idx <= blk_len && tok_ok)
                card_mem[mem_index(wr_addr, idx - 1)] = b;
            idx++;
            if (idx >= blk_len + 3)
            begin
                idx      = 0;
                wr_phase = 1'b0;
                if (!tok_ok)
                    queue_resp(sdspi_pkg::R_DATA_BAD);
                else
                begin
                    queue_resp(sdspi_pkg::R_DATA_OK);
                    queue_resp(sdspi_pkg::R_OK);
                    queue_resp(sdspi_pkg::R_FILL);
                end
                tok_ok = 1'b0;
            end
        end
    endtask

    // Works out the output beat caused by one input beat.
    task automatic predict_beat(sdspi_pkg::in_beat_t beat);
        sdspi_pkg::out_beat_t exp_beat;
        exp_beat.miso_byte = sdspi_pkg::R_FILL;
        if (beat.command)
        begin
            clear_engine();
            card_sel = 1'b1;
        end
        else if (card_sel)
        begin
            if (resp_fifo.size() != 0)
                exp_beat.miso_byte = resp_fifo.pop_front();
            if (!(beat.mosi_byte == HOST_IDLE && idx == 0))
                consume_byte(beat.mosi_byte);
        end
        exp_beat.overflow = resp_ovf;
        expected_beats.push_back(exp_beat);
    endtask

    initial
    begin
        errors = 0;
        foreach (card_mem[i]) card_mem[i] = 8'h00;
        clear_engine();
    end

    // Output beats are checked before the input beat of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        sdspi_pkg::out_beat_t want;
        if (!rst_n)
        begin
            clear_engine();
            foreach (card_mem[i]) card_mem[i] = 8'h00;
            expected_beats.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected: miso %h ovf %b",
                             $time, out_data.miso_byte, out_data.overflow);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_data.miso_byte !== want.miso_byte)
                    begin
                        $display("%0t: miso_byte expected %h actual %h",
                                 $time, want.miso_byte, out_data.miso_byte);
                        errors++;
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, out_data.overflow);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_beat(in_data);
        end
    end

endmodule

[tb/tb.sv]
// Top of the SD card SPI command engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic [7:0] HOST_IDLE  = 8'hFF;
    localparam logic [7:0] CMD_UNUSED = 8'h3F;
    localparam int         ITEM_GOAL  = 650;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    sdspi_pkg::in_beat_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    sdspi_pkg::out_beat_t out_data;
    int                   errors;
    int                   pending;

    int        sent;
    int        blen;
    int        hold_left;
    logic      held = 1'b0;
    logic      quiet;

    sd_card_spi_command_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sd_card_spi_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A stretch with no idling on either side.
    assign quiet = (sent >= 400) && (sent < 560);

    // Receiver: random stalls plus one long hold-off that backs the block up.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (sent == 200 && !held)
        begin
            out_ready <= 1'b0;
            hold_left <= 500;
            held      <= 1'b1;
        end
        else
            out_ready <= quiet || ($urandom % 100 >= 8);
    end

    // Sends one beat and waits for it to be taken, then maybe idles.
    task automatic send(logic cmd, logic [7:0] b);
        in_valid          <= 1'b1;
        in_data.command   <= cmd;
        in_data.mosi_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        if (!quiet && $urandom % 100 < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic select_card();
        send(1'b1, 8'($urandom));
        blen = 1024;
    endtask

    task automatic cmd_frame(logic [5:0] idx, logic [31:0] arg);
        send(1'b0, {($urandom % 4 == 0) ? 2'($urandom) : 2'b01, idx});
        send(1'b0, arg[31:24]);
        send(1'b0, arg[23:16]);
        send(1'b0, arg[15:8]);
        send(1'b0, arg[7:0]);
        send(1'b0, 8'($urandom));
        if (idx == sdspi_pkg::CMD_SET_BLEN)
            blen = (arg > sdspi_pkg::MAX_BLOCK_DEF) ? sdspi_pkg::MAX_BLOCK_DEF : arg;
    endtask

    task automatic idle_bytes(int n);
        repeat (n) send(1'b0, HOST_IDLE);
    endtask

    // Data phase of a write: optional idle lead-in, token, block, two CRC bytes.
    task automatic write_data(logic [7:0] token);
        idle_bytes($urandom_range(0, 2));
        send(1'b0, token);
        repeat (blen) send(1'b0, 8'($urandom));
        send(1'b0, 8'($urandom));
        send(1'b0, 8'($urandom));
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom % 8)
            0: return $urandom | 32'h4000_0000;
            1, 2: return $urandom & 32'h3FFF_FFFF;
            3: return 32'h0000_FFF0 + $urandom_range(0, 15);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial
    begin
        logic [31:0] addr;
        logic [7:0]  tok;
        int          pick;
        sent      = 0;
        blen      = 1024;
        hold_left = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Exchanges before any select are ignored.
        send(1'b0, 8'h00);
        send(1'b0, HOST_IDLE);
        select_card();
        idle_bytes(2);
        cmd_frame(sdspi_pkg::CMD_GO_IDLE, 32'h0);
        cmd_frame(6'(sdspi_pkg::CMD_OP_COND), 32'h0);
        cmd_frame(sdspi_pkg::CMD_APP, 32'h0);
        cmd_frame(sdspi_pkg::CMD_OP_COND, 32'hFFFF_FFFF);
        cmd_frame(6'(CMD_UNUSED), 32'h1234_5678);
        // Short block written across the top of the store, then read back.
        cmd_frame(sdspi_pkg::CMD_SET_BLEN, 32'd4);
        cmd_frame(sdspi_pkg::CMD_WRITE_BLK, 32'h0000_FFFE);
        write_data(sdspi_pkg::R_TOKEN);
        cmd_frame(sdspi_pkg::CMD_READ_BLK, 32'h0000_FFFE);
        idle_bytes(10);
        cmd_frame(sdspi_pkg::CMD_WRITE_BLK, 32'h0000_0010);
        write_data(8'h00);
        cmd_frame(sdspi_pkg::CMD_READ_BLK, 32'h4000_0000);
        cmd_frame(sdspi_pkg::CMD_WRITE_BLK, 32'hFFFF_FFFF);
        cmd_frame(sdspi_pkg::CMD_SET_BLEN, 32'd0);
        cmd_frame(sdspi_pkg::CMD_READ_BLK, 32'h0);
        cmd_frame(sdspi_pkg::CMD_WRITE_BLK, 32'h0);
        write_data(sdspi_pkg::R_TOKEN);
        // Largest block twice over the response queue, then select to recover.
        cmd_frame(sdspi_pkg::CMD_SET_BLEN, 32'hFFFF_FFFF);
        cmd_frame(sdspi_pkg::CMD_READ_BLK, 32'h0000_FFF0);
        cmd_frame(sdspi_pkg::CMD_READ_BLK, 32'h0);
        idle_bytes(4);
        select_card();

        // Mostly well-formed command sequences with random content.
        while (sent < ITEM_GOAL)
        begin
            pick = $urandom % 100;
            if (blen > 64)
                cmd_frame(sdspi_pkg::CMD_SET_BLEN, $urandom_range(0, 24));
            else if (pick < 12)
            begin
                if ($urandom % 6 == 0)
                    cmd_frame(sdspi_pkg::CMD_SET_BLEN, $urandom);
                cmd_frame(sdspi_pkg::CMD_SET_BLEN, $urandom_range(0, 24));
            end
            else if (pick < 30)
                cmd_frame(sdspi_pkg::CMD_READ_BLK, pick_addr());
            else if (pick < 50)
            begin
                addr = pick_addr();
                cmd_frame(sdspi_pkg::CMD_WRITE_BLK, addr);
                if (addr < 32'h4000_0000)
                begin
                    tok = ($urandom % 8 == 0) ? 8'($urandom_range(0, 254)) : sdspi_pkg::R_TOKEN;
                    write_data(tok);
                end
            end
            else if (pick < 60)
            begin
                case ($urandom % 4)
                    0: cmd_frame(sdspi_pkg::CMD_GO_IDLE, $urandom);
                    1: cmd_frame(sdspi_pkg::CMD_APP, $urandom);
                    2: cmd_frame(sdspi_pkg::CMD_OP_COND, $urandom);
                    default: cmd_frame(6'($urandom), $urandom);
                endcase
            end
            else if (pick < 68)
            begin
                // Noise can leave the engine anywhere; a select puts it back.
                repeat ($urandom_range(1, 6)) send(1'b0, 8'($urandom));
                select_card();
            end
            else if (pick < 72)
                select_card();
            else
                idle_bytes($urandom_range(1, 12));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: errors");
        $finish;
    end

endmodule
